// File: hdl/brcc_pkg.sv
// Shared constants and types for the balance robot cascade controller.
package brcc_pkg;

  // Configuration register indexes
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t REG_BALANCE_KP    = 3'd0;
  localparam cfg_index_t REG_BALANCE_KD    = 3'd1;
  localparam cfg_index_t REG_SPEED_KP      = 3'd2;
  localparam cfg_index_t REG_SPEED_KI      = 3'd3;
  localparam cfg_index_t REG_YAW_RATE_GAIN = 3'd4;
  localparam cfg_index_t REG_STEER_GAIN    = 3'd5;
  localparam cfg_index_t REG_BALANCE_ANGLE = 3'd6;
  localparam cfg_index_t REG_DRIVE_LIMIT   = 3'd7;

  localparam logic [12:0] DRIVE_LIMIT_RESET = 13'd7000;

  // Command clamps
  localparam logic signed [7:0] SPEED_CMD_MAX = 8'sd100;
  localparam logic signed [7:0] TURN_CMD_MAX  = 8'sd80;

  // Pitch thresholds, Q8.8 degrees (12 and 40 degrees)
  localparam logic signed [16:0] TRIP_ANGLE  = 17'sd3072;
  localparam logic signed [16:0] CLEAR_ANGLE = 17'sd10240;

  // Speed integral, Q15.8, saturates at +-10000.0
  localparam int INTEG_W = 23;
  localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 23'sd2560000;

  // Filtered wheel speed, Q.8; magnitude never exceeds 256 * 65535
  localparam int FS_W = 25;
  localparam logic signed [FS_W-1:0] FS_MAX = 25'sd16776960;

  // Divide by 5: multiply by ceil(2^30 / 5), exact for magnitudes below 2^27
  localparam int RECIP5_W     = 28;
  localparam int RECIP5_SHIFT = 30;
  localparam logic [RECIP5_W-1:0] RECIP5 = 28'd214748365;

endpackage

// File: hdl/brcc_speed_filter.sv
// Low-pass filter on the wheel speed sum: fs = trunc((4*fs + 256*sum) / 5).
module brcc_speed_filter import brcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic signed [15:0]     left_count,
  input  logic signed [15:0]     right_count,
  output logic signed [FS_W-1:0] speed
);

  logic signed [16:0]        wheel_sum;
  logic signed [FS_W+2:0]    num;
  logic        [FS_W+2:0]    num_abs;
  logic        [FS_W+1:0]    mag;
  logic [FS_W+1+RECIP5_W:0]  prod;
  logic        [FS_W-1:0]    quot;
  logic signed [FS_W-1:0]    speed_next;

  // Form the filter numerator; right wheel counts are negated
  assign wheel_sum = left_count - right_count;
  assign num       = (speed <<< 2) + (wheel_sum <<< 8);

  // Divide the magnitude by 5 with a reciprocal multiply, restore the sign
  assign num_abs    = num[FS_W+2] ? 28'(-num) : 28'(num);
  assign mag        = num_abs[FS_W+1:0];
  assign prod       = mag * RECIP5;
  assign quot       = prod[FS_W+1+RECIP5_W:RECIP5_SHIFT];
  assign speed_next = num[FS_W+2] ? -$signed(quot) : $signed(quot);

  // Advance the filter once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
    end else if (step) begin
      speed <= speed_next;
    end
  end

endmodule

// File: hdl/balance_robot_cascade_controller.sv
// Top level: two-wheel balance controller (balance PD, speed PI, turn) with drive mixing.
//
// One control tick enters per clock cycle unless the pipeline is held, and its drive
// result passes the input register, three pipeline stages and the output register.
// The per-item state recurrences set that single-cycle rate: the wheel speed filter
// closes its loop through one reciprocal multiplier in stage one, and the speed
// integral closes its loop through one add and clamp in stage two. While a result
// is held by result_stall the whole pipeline holds, and item_stall is raised.
// Configuration writes are taken at any time through cfg_valid/cfg_ready
// (cfg_ready is always high) and must only be made while the block is idle.
module balance_robot_cascade_controller import brcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_index_t         cfg_index,
  input  logic [15:0]        cfg_data,
  // input item channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [16:0] pitch_angle,
  input  logic signed [15:0] pitch_rate,
  input  logic signed [15:0] yaw_rate,
  input  logic signed [15:0] left_count,
  input  logic signed [15:0] right_count,
  input  logic signed [7:0]  speed_command,
  input  logic signed [7:0]  turn_command,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [13:0] left_drive,
  output logic signed [13:0] right_drive,
  output logic               tilt_trip
);

  // Configuration registers
  logic signed [15:0] balance_kp, balance_kd, speed_kp, speed_ki;
  logic signed [15:0] yaw_rate_gain, steer_gain;
  logic signed [13:0] balance_angle;
  logic        [12:0] drive_limit;

  // Pipeline control
  logic advance, accept;
  logic s0_valid, a_valid, b_valid, c_valid;

  // Input register
  logic signed [16:0] s0_pitch;
  logic signed [15:0] s0_prate, s0_yrate, s0_lcnt, s0_rcnt;
  logic signed [7:0]  s0_scmd, s0_tcmd;

  // Stage A
  logic signed [17:0] err;
  logic signed [7:0]  scmd_c, tcmd_c;
  logic signed [33:0] pb1;
  logic signed [31:0] pb2, pt1;
  logic signed [23:0] pt2;
  logic               trip, clear;
  logic signed [33:0] a_pb1;
  logic signed [31:0] a_pb2, a_pt1;
  logic signed [23:0] a_pt2;
  logic signed [7:0]  a_scmd;
  logic               a_trip, a_clear;
  logic signed [FS_W-1:0] speed;

  // Stage B
  logic signed [INTEG_W-1:0] integral;
  logic signed [26:0]        integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [40:0]        pv1, bal_sum, bal_adj;
  logic signed [38:0]        pv2;
  logic signed [32:0]        turn_sum, turn_adj;
  logic signed [40:0]        b_pv1;
  logic signed [38:0]        b_pv2;
  logic signed [24:0]        b_bal, b_turn;
  logic                      b_trip;

  // Stage C
  logic signed [41:0] vel_sum, vel_adj;
  logic signed [25:0] c_vel;
  logic signed [24:0] c_bal, c_turn;
  logic               c_trip;

  // Output stage
  logic signed [27:0] mix_l, mix_r, lim;

  function automatic logic signed [13:0] sat_drive(input logic signed [27:0] v,
                                                   input logic signed [27:0] limit);
    logic signed [27:0] r;
    if (v > limit) begin
      r = limit;
    end else if (v < -limit) begin
      r = -limit;
    end else begin
      r = v;
    end
    return r[13:0];
  endfunction

  // Take configuration writes; unknown indexes fall through
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      balance_kp    <= '0;
      balance_kd    <= '0;
      speed_kp      <= '0;
      speed_ki      <= '0;
      yaw_rate_gain <= '0;
      steer_gain    <= '0;
      balance_angle <= '0;
      drive_limit   <= DRIVE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BALANCE_KP:    balance_kp    <= cfg_data;
        REG_BALANCE_KD:    balance_kd    <= cfg_data;
        REG_SPEED_KP:      speed_kp      <= cfg_data;
        REG_SPEED_KI:      speed_ki      <= cfg_data;
        REG_YAW_RATE_GAIN: yaw_rate_gain <= cfg_data;
        REG_STEER_GAIN:    steer_gain    <= cfg_data;
        REG_BALANCE_ANGLE: balance_angle <= cfg_data[13:0];
        REG_DRIVE_LIMIT:   drive_limit   <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // Hold the whole pipeline while a result waits to be taken
  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance;
  assign accept     = item_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid     <= 1'b0;
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s0_valid     <= accept;
      a_valid      <= s0_valid;
      b_valid      <= a_valid;
      c_valid      <= b_valid;
      result_valid <= c_valid;
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_pitch <= pitch_angle;
      s0_prate <= pitch_rate;
      s0_yrate <= yaw_rate;
      s0_lcnt  <= left_count;
      s0_rcnt  <= right_count;
      s0_scmd  <= speed_command;
      s0_tcmd  <= turn_command;
    end
  end

  // Stage A: clamp commands, form balance and turn products, check tilt
  assign err    = s0_pitch - balance_angle;
  assign scmd_c = (s0_scmd > SPEED_CMD_MAX) ? SPEED_CMD_MAX :
                  (s0_scmd < -SPEED_CMD_MAX) ? -SPEED_CMD_MAX : s0_scmd;
  assign tcmd_c = (s0_tcmd > TURN_CMD_MAX) ? TURN_CMD_MAX :
                  (s0_tcmd < -TURN_CMD_MAX) ? -TURN_CMD_MAX : s0_tcmd;
  assign pb1    = balance_kp * err;
  assign pb2    = balance_kd * s0_prate;
  assign pt1    = yaw_rate_gain * s0_yrate;
  assign pt2    = steer_gain * tcmd_c;
  assign trip   = (s0_pitch > TRIP_ANGLE) || (s0_pitch < -TRIP_ANGLE);
  assign clear  = (s0_pitch > CLEAR_ANGLE) || (s0_pitch < -CLEAR_ANGLE);

  brcc_speed_filter u_speed_filter (
    .clk         (clk),
    .rst         (rst),
    .step        (advance && s0_valid),
    .left_count  (s0_lcnt),
    .right_count (s0_rcnt),
    .speed       (speed)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      a_pb1   <= pb1;
      a_pb2   <= pb2;
      a_pt1   <= pt1;
      a_pt2   <= pt2;
      a_scmd  <= scmd_c;
      a_trip  <= trip;
      a_clear <= clear;
    end
  end

  // Stage B: update the speed integral, form velocity products, scale B and T
  assign integ_sum = integral + speed - $signed({a_scmd, 8'b0});
  assign integ_sat = (integ_sum > INTEG_LIMIT) ? INTEG_LIMIT :
                     (integ_sum < -INTEG_LIMIT) ? -INTEG_LIMIT :
                     integ_sum[INTEG_W-1:0];
  assign pv1       = speed * speed_kp;
  assign pv2       = integ_sat * speed_ki;
  assign bal_sum   = a_pb1 + (a_pb2 <<< 8);
  assign bal_adj   = bal_sum + $signed({25'b0, {16{bal_sum[40]}}});
  assign turn_sum  = a_pt1 + a_pt2;
  assign turn_adj  = turn_sum + $signed({25'b0, {8{turn_sum[32]}}});

  // Clear the integral on a large tilt after its use in this tick
  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else if (advance && a_valid) begin
      integral <= a_clear ? '0 : integ_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_pv1  <= pv1;
      b_pv2  <= pv2;
      b_bal  <= bal_adj[40:16];
      b_turn <= turn_adj[32:8];
      b_trip <= a_trip;
    end
  end

  // Stage C: scale the velocity term toward zero
  assign vel_sum = b_pv1 + b_pv2;
  assign vel_adj = vel_sum + $signed({26'b0, {16{vel_sum[41]}}});

  always_ff @(posedge clk) begin
    if (advance) begin
      c_vel  <= vel_adj[41:16];
      c_bal  <= b_bal;
      c_turn <= b_turn;
      c_trip <= b_trip;
    end
  end

  // Output stage: mix, saturate, force zero on tilt trip
  assign mix_l = c_bal - c_vel + c_turn;
  assign mix_r = c_bal - c_vel - c_turn;
  assign lim   = $signed({15'b0, drive_limit});

  always_ff @(posedge clk) begin
    if (advance) begin
      left_drive  <= c_trip ? '0 : sat_drive(mix_l, lim);
      right_drive <= c_trip ? '0 : sat_drive(mix_r, lim);
      tilt_trip   <= c_trip;
    end
  end

  // Checks
  a_trip_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && tilt_trip |-> left_drive == '0 && right_drive == '0)
    else $error("drive not zero on tilt trip");

  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    integral <= INTEG_LIMIT && integral >= -INTEG_LIMIT)
    else $error("speed integral out of bound");

  a_speed_bound: assert property (@(posedge clk) disable iff (rst)
    speed <= FS_MAX && speed >= -FS_MAX)
    else $error("filtered speed out of bound");

  a_integ_hold: assert property (@(posedge clk) disable iff (rst)
    !a_valid |=> $stable(integral))
    else $error("speed integral moved without an item");

endmodule
